// ===== hw/rtl/sms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sms_pkg
// shared types, sizes and codes of the sorted multiset store
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] entry;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } res_t;

    typedef struct packed {
        logic       load;
        logic       ins;
        logic       clr;
        logic       del;
        logic       rd;
        logic       emit;
        logic [1:0] status;
        logic       last;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       full;
        logic       hit;
        logic       rd_last;
    } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sms_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sms_ctrl
// command sequencer: decodes a transaction and steps the datapath
// ----------------------------------------------------------------------------
module sms_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sms_pkg::stat_t stat,
    output sms_pkg::ctrl_t     ctrl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        ctrl.status = sms_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.last  = 1'b1;
                state_next = S_IDLE;
                case (stat.cmd)
                    sms_pkg::CMD_INSERT:
                    begin
                        ctrl.emit = 1'b1;
                        if (stat.full)
                        begin
                            ctrl.status = sms_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.ins = 1'b1;
                        end
                    end
                    sms_pkg::CMD_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.emit   = 1'b1;
                            ctrl.status = sms_pkg::ST_EMPTY;
                        end
                        else if (!stat.hit)
                        begin
                            ctrl.emit   = 1'b1;
                            ctrl.status = sms_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            ctrl.del   = 1'b1;
                            state_next = S_DEL;
                        end
                    end
                    sms_pkg::CMD_READ:
                    begin
                        ctrl.emit = 1'b1;
                        if (stat.empty)
                        begin
                            ctrl.status = sms_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.rd   = 1'b1;
                            ctrl.last = stat.rd_last;
                            if (!stat.rd_last)
                            begin
                                state_next = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        ctrl.emit = 1'b1;
                        ctrl.clr  = 1'b1;
                    end
                endcase
            end
            S_DEL:
            begin
                if (stat.hit)
                begin
                    ctrl.del = 1'b1;
                end
                else
                begin
                    ctrl.emit  = 1'b1;
                    ctrl.last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                ctrl.emit = 1'b1;
                ctrl.rd   = 1'b1;
                ctrl.last = stat.rd_last;
                if (stat.rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sms_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sms_dpath
// sorted entry cells with parallel compare and shift, result register
// ----------------------------------------------------------------------------
module sms_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sms_pkg::req_t request,
    input  wire sms_pkg::ctrl_t ctrl,
    output sms_pkg::stat_t     stat,
    output sms_pkg::res_t      result,
    output logic               done
);

    logic [1:0]                        cmd_reg;
    logic signed [sms_pkg::DATA_W-1:0] value_reg;
    logic signed [sms_pkg::DATA_W-1:0] entries_reg [sms_pkg::DEPTH];
    logic signed [sms_pkg::DATA_W-1:0] entries_next [sms_pkg::DEPTH];
    logic [sms_pkg::OCC_W-1:0]         occ_reg;
    logic [sms_pkg::OCC_W-1:0]         occ_next;
    logic [sms_pkg::IDX_W-1:0]         idx_reg;
    logic [sms_pkg::IDX_W-1:0]         idx_next;
    sms_pkg::res_t                     res_reg;
    sms_pkg::res_t                     res_next;
    logic                              done_reg;

    logic [sms_pkg::DEPTH-1:0] live;
    logic [sms_pkg::DEPTH-1:0] ge;
    logic [sms_pkg::DEPTH-1:0] eq;
    logic [sms_pkg::DEPTH-1:0] sel;

    // per-cell compare against the operand
    always_comb
    begin
        for (int i = 0; i < sms_pkg::DEPTH; i++)
        begin
            live[i] = (sms_pkg::OCC_W'(i) < occ_reg);
            ge[i]   = live[i] && (entries_reg[i] >= value_reg);
            eq[i]   = live[i] && (entries_reg[i] == value_reg);
            sel[i]  = ge[i] || !live[i];
        end
    end

    assign stat.cmd     = cmd_reg;
    assign stat.empty   = (occ_reg == '0);
    assign stat.full    = (occ_reg == sms_pkg::OCC_W'(sms_pkg::DEPTH));
    assign stat.hit     = |eq;
    assign stat.rd_last = ((sms_pkg::OCC_W'(idx_reg) + sms_pkg::OCC_W'(1)) == occ_reg);

    // insert opens a gap at the first cell >= value, delete closes the first match
    always_comb
    begin
        for (int i = 0; i < sms_pkg::DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (ctrl.ins && sel[i])
            begin
                if (i == 0)
                begin
                    entries_next[i] = value_reg;
                end
                else if (sel[i-1])
                begin
                    entries_next[i] = entries_reg[i-1];
                end
                else
                begin
                    entries_next[i] = value_reg;
                end
            end
            else if (ctrl.del && ge[i] && (i < sms_pkg::DEPTH - 1))
            begin
                entries_next[i] = entries_reg[i+1];
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.clr)
        begin
            occ_next = '0;
        end
        else if (ctrl.ins)
        begin
            occ_next = occ_reg + sms_pkg::OCC_W'(1);
        end
        else if (ctrl.del)
        begin
            occ_next = occ_reg - sms_pkg::OCC_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.load)
        begin
            idx_next = '0;
        end
        else if (ctrl.rd)
        begin
            idx_next = idx_reg + sms_pkg::IDX_W'(1);
        end
    end

    always_comb
    begin
        res_next        = res_reg;
        res_next.status = ctrl.status;
        res_next.entry  = ctrl.rd ? entries_reg[idx_reg] : '0;
        res_next.count  = sms_pkg::CNT_W'(occ_next);
        res_next.last   = ctrl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            idx_reg  <= idx_next;
            done_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= request.cmd;
            value_reg <= request.value;
        end
        if (ctrl.emit)
        begin
            res_reg <= res_next;
        end
        for (int i = 0; i < sms_pkg::DEPTH; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_multiset_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_store
// bounded multiset of signed values kept in ascending order
//
//   channel   handshake        payload
//   request   start / busy     request.cmd, request.value
//   result    done (strobe)    result.status, result.entry, result.count,
//                              result.last
//
// a transaction is taken when start is high and busy is low.
// insert, clear, unmatched delete and empty readout: one result, registered
// from the execute state once the transaction is taken.
// delete of k equal entries: one shift of the cell row per entry.
// readout of n entries: one result per cycle from the cell row.
// reset empties the store at once; the receiver takes every result as shown.
// ----------------------------------------------------------------------------
module sorted_multiset_store (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sms_pkg::req_t request,
    output sms_pkg::res_t      result,
    output logic               done
);

    sms_pkg::ctrl_t ctrl;
    sms_pkg::stat_t stat;

    sms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    sms_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

endmodule
`default_nettype wire

// ===== verif/sorted_multiset_store_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_store_test
// checks the sorted multiset store against a behavioral store kept in the
// bench: a short scripted run over empty, full, duplicate and extreme values
// and every command, then a couple of hundred random commands that swing
// between filling and draining the store, with random sender gaps and drain
// pauses
// ----------------------------------------------------------------------------
module sorted_multiset_store_test;

    localparam int RANDOM_ITEMS = 214;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int SCRIPT_LEN = 24;

    typedef struct {
        logic [1:0]                 cmd;
        logic [sms_pkg::DATA_W-1:0] value;
        int                         reps;
        bit                         typed;
        logic [1:0]                 status;
        logic [sms_pkg::CNT_W-1:0]  count;
    } script_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    sms_pkg::req_t request;
    sms_pkg::res_t result;
    logic          done;

    logic signed [sms_pkg::DATA_W-1:0] held_values [sms_pkg::DEPTH];
    int                                held_count;
    sms_pkg::res_t                     expected_results [$];
    int                                failures;
    int                                cycles;

    script_row_t script [SCRIPT_LEN] = '{
        '{sms_pkg::CMD_READ,   32'h0000_0000,  1, 1, sms_pkg::ST_EMPTY,     5'd0},
        '{sms_pkg::CMD_DELETE, 32'h8000_0000,  1, 1, sms_pkg::ST_EMPTY,     5'd0},
        '{sms_pkg::CMD_CLEAR,  32'hffff_ffff,  1, 1, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_INSERT, 32'h7fff_ffff,  1, 1, sms_pkg::ST_OK,        5'd1},
        '{sms_pkg::CMD_INSERT, 32'h8000_0000,  1, 1, sms_pkg::ST_OK,        5'd2},
        '{sms_pkg::CMD_INSERT, 32'h0000_0000,  1, 1, sms_pkg::ST_OK,        5'd3},
        '{sms_pkg::CMD_INSERT, 32'hffff_ffff,  1, 1, sms_pkg::ST_OK,        5'd4},
        '{sms_pkg::CMD_INSERT, 32'h0000_0000,  1, 1, sms_pkg::ST_OK,        5'd5},
        '{sms_pkg::CMD_DELETE, 32'h0000_0005,  1, 1, sms_pkg::ST_NOT_FOUND, 5'd5},
        '{sms_pkg::CMD_READ,   32'haaaa_aaaa,  1, 0, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_DELETE, 32'h0000_0000,  1, 1, sms_pkg::ST_OK,        5'd3},
        '{sms_pkg::CMD_READ,   32'h5555_5555,  1, 0, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_INSERT, 32'h0000_0007, 13, 0, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_INSERT, 32'h7fff_ffff,  1, 1, sms_pkg::ST_FULL,      5'd16},
        '{sms_pkg::CMD_INSERT, 32'h8000_0000,  1, 1, sms_pkg::ST_FULL,      5'd16},
        '{sms_pkg::CMD_READ,   32'h0000_0000,  1, 0, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_DELETE, 32'h0000_0007,  1, 1, sms_pkg::ST_OK,        5'd3},
        '{sms_pkg::CMD_DELETE, 32'h7fff_ffff,  1, 1, sms_pkg::ST_OK,        5'd2},
        '{sms_pkg::CMD_DELETE, 32'h8000_0000,  1, 1, sms_pkg::ST_OK,        5'd1},
        '{sms_pkg::CMD_READ,   32'hffff_ffff,  1, 0, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_DELETE, 32'hffff_ffff,  1, 1, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_READ,   32'h1234_5678,  1, 1, sms_pkg::ST_EMPTY,     5'd0},
        '{sms_pkg::CMD_INSERT, 32'h5555_5555,  1, 0, sms_pkg::ST_OK,        5'd0},
        '{sms_pkg::CMD_CLEAR,  32'h0000_0000,  1, 1, sms_pkg::ST_OK,        5'd0}
    };

    sorted_multiset_store dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .done    (done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles == LIMIT_CYCLES);
        $display("%0t: run did not finish, %0d results outstanding", $time,
                 expected_results.size());
        $display("tb: failure");
        $finish;
    end

    function automatic sms_pkg::res_t make_result(logic [1:0] status,
                                                  logic [sms_pkg::DATA_W-1:0] entry,
                                                  bit last);
        sms_pkg::res_t r;
        r.status = status;
        r.entry  = entry;
        r.count  = sms_pkg::CNT_W'(held_count);
        r.last   = last;
        return r;
    endfunction

    // ordered store update; queues what the command should return when asked to
    function automatic void apply_command(sms_pkg::req_t r, bit queue_results);
        int pos;
        int kept;
        sms_pkg::res_t outs [$];
        if (r.cmd == sms_pkg::CMD_INSERT)
        begin
            if (held_count >= sms_pkg::DEPTH)
                outs.push_back(make_result(sms_pkg::ST_FULL, '0, 1'b1));
            else
            begin
                pos = 0;
                while (pos < held_count && r.value > held_values[pos])
                    pos++;
                for (int j = held_count; j > pos; j--)
                    held_values[j] = held_values[j-1];
                held_values[pos] = r.value;
                held_count++;
                outs.push_back(make_result(sms_pkg::ST_OK, '0, 1'b1));
            end
        end
        else if (r.cmd == sms_pkg::CMD_DELETE)
        begin
            if (held_count == 0)
                outs.push_back(make_result(sms_pkg::ST_EMPTY, '0, 1'b1));
            else
            begin
                kept = 0;
                for (int j = 0; j < held_count; j++)
                    if (held_values[j] != r.value)
                    begin
                        held_values[kept] = held_values[j];
                        kept++;
                    end
                if (kept == held_count)
                    outs.push_back(make_result(sms_pkg::ST_NOT_FOUND, '0, 1'b1));
                else
                begin
                    held_count = kept;
                    outs.push_back(make_result(sms_pkg::ST_OK, '0, 1'b1));
                end
            end
        end
        else if (r.cmd == sms_pkg::CMD_READ)
        begin
            if (held_count == 0)
                outs.push_back(make_result(sms_pkg::ST_EMPTY, '0, 1'b1));
            else
                for (int j = 0; j < held_count; j++)
                    outs.push_back(make_result(sms_pkg::ST_OK, held_values[j],
                                               j + 1 == held_count));
        end
        else
        begin
            held_count = 0;
            outs.push_back(make_result(sms_pkg::ST_OK, '0, 1'b1));
        end
        if (queue_results)
            foreach (outs[k])
                expected_results.push_back(outs[k]);
    endfunction

    function automatic logic [sms_pkg::DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return sms_pkg::DATA_W'($urandom_range(0, 8)) - sms_pkg::DATA_W'(4);
        else if (roll == 6)
            case ($urandom_range(0, 2))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                default: return 32'hffff_ffff;
            endcase
        return sms_pkg::DATA_W'($urandom);
    endfunction

    // one transaction: hold start until busy is low at a rising edge
    task automatic issue(logic [1:0] cmd, logic [sms_pkg::DATA_W-1:0] value, bit typed,
                         logic [1:0] status, logic [sms_pkg::CNT_W-1:0] count);
        sms_pkg::req_t r;
        sms_pkg::res_t want;
        r.cmd   = cmd;
        r.value = value;
        @(negedge clk);
        start   = 1'b1;
        request = r;
        do
            @(posedge clk);
        while (busy);
        apply_command(r, !typed);
        if (typed)
        begin
            want.status = status;
            want.entry  = '0;
            want.count  = count;
            want.last   = 1'b1;
            expected_results.push_back(want);
        end
    endtask

    task automatic hold_off(int gap, bit drain);
        if (gap > 0 || drain)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap > 0 ? gap - 1 : 0)
                @(negedge clk);
            while (drain && expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic report(string field, logic [sms_pkg::DATA_W-1:0] want,
                          logic [sms_pkg::DATA_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        failures++;
    endtask

    always @(posedge clk)
    begin
        sms_pkg::res_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, result);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report("status", sms_pkg::DATA_W'(want.status),
                           sms_pkg::DATA_W'(result.status));
                if (result.entry !== want.entry)
                    report("entry", want.entry, result.entry);
                if (result.count !== want.count)
                    report("count", sms_pkg::DATA_W'(want.count),
                           sms_pkg::DATA_W'(result.count));
                if (result.last !== want.last)
                    report("last", sms_pkg::DATA_W'(want.last),
                           sms_pkg::DATA_W'(result.last));
            end
        end
    end

    initial
    begin
        logic [1:0]                 cmd;
        logic [sms_pkg::DATA_W-1:0] value;
        int                         roll;
        int                         gap;
        bit                         filling;
        bit                         quiet;
        held_count = 0;
        start      = 1'b0;
        request    = '0;
        rst_n      = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // scripted transactions
        foreach (script[i])
            for (int k = 0; k < script[i].reps; k++)
            begin
                issue(script[i].cmd, script[i].value, script[i].typed,
                      script[i].status, script[i].count);
                hold_off($urandom_range(0, 2), 1'b0);
            end
        hold_off(0, 1'b1);

        // random transactions, alternating fill and drain bias
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            filling = ((n / 40) % 2) == 0;
            quiet   = ((n / 25) % 3) == 2;
            roll    = $urandom_range(0, 99);
            if (roll < 3)
                cmd = sms_pkg::CMD_CLEAR;
            else if (roll < 15)
                cmd = sms_pkg::CMD_READ;
            else if (roll < (filling ? 80 : 45))
                cmd = sms_pkg::CMD_INSERT;
            else
                cmd = sms_pkg::CMD_DELETE;
            value = pick_value();
            if (cmd == sms_pkg::CMD_DELETE && held_count > 0 && $urandom_range(0, 2) != 0)
                value = held_values[$urandom_range(0, held_count - 1)];
            issue(cmd, value, 1'b0, sms_pkg::ST_OK, '0);
            roll = $urandom_range(0, 99);
            if (quiet || roll < 55)
                gap = 0;
            else if (roll < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(4, 30);
            hold_off(gap, !quiet && $urandom_range(0, 99) < 4 || n == RANDOM_ITEMS / 2);
        end

        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/sms_pkg.sv
hw/rtl/sms_ctrl.sv
hw/rtl/sms_dpath.sv
hw/rtl/sorted_multiset_store.sv
verif/sorted_multiset_store_test.sv
